/* hdl/euler_cell_positivity_check_assert.svh */
// Assertion macros for the Euler cell positivity checker.
// Used by modules that hold clk and rst_n; no other dependencies.
`ifndef EULER_CELL_POSITIVITY_CHECK_ASSERT_SVH
`define EULER_CELL_POSITIVITY_CHECK_ASSERT_SVH

// Clocked property check, quiet while reset is held
`define ECPC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that an expression never holds
`define ECPC_NEVER(lbl, expr, msg) \
  `ECPC_ASSERT(lbl, !(expr), msg)

`endif

/* hdl/ecpc_pkg.sv */
// Shared types and constants for the Euler cell positivity checker.
// No dependencies.
package ecpc_pkg;

  localparam int NODES_PER_SIDE = 4;
  localparam int IDX_W          = 2;
  localparam int NQ             = 4;
  localparam int ACC_W          = 48;
  localparam logic [15:0] GAMMA_ONE = 16'd4096;

  // Queue entry: node state plus its place in the cell
  typedef struct packed {
    logic signed [31:0] rho;
    logic signed [31:0] mx;
    logic signed [31:0] my;
    logic signed [31:0] e;
    logic               last;
    logic [IDX_W-1:0]   ix;
    logic [IDX_W-1:0]   iy;
  } item_t;

endpackage

/* hdl/euler_cell_positivity_check.sv */
// Top level of the Euler cell positivity checker: configuration registers,
// front queue and back engine. Depends on ecpc_pkg, ecpc_front, ecpc_back.
//
// Usage: nodes of one cell enter on the in_ stream in row-major order, one
// item per node, in_tlast on the final node. One item with cell_ok in bit 0
// leaves on the out_ stream for each node marked last; others give nothing.
// Face weights and gamma are written through cfg_we/cfg_index/cfg_data;
// the user must do so only while the block is idle, which is not enforced.
// The engine takes a new node only once the last one has retired. A single
// shared 32x32 multiplier does the sixteen accumulations and the pressure
// products. Each node is popped, accumulated and tested as a state; faces
// are tested when the node closes a row or column; then the node retires.
// A two-entry input queue lets the sender run ahead, and the result register
// lets the engine keep working while out_tready is low; it holds only when
// a second result is due before the first is taken.
// Reset (rst_n low, synchronous) loads default weights and gamma, clears all
// sums and the position, and empties queue and result register.
module euler_cell_positivity_check import ecpc_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,   // density, momentum_x, momentum_y, total_energy
  input  logic         in_tlast,   // last_node
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [7:0]   out_tdata,  // cell_ok, then zero fill
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [63:0]  cfg_data
);

  localparam logic [1:0] REG_LEFT  = 2'd0;
  localparam logic [1:0] REG_RIGHT = 2'd1;
  localparam logic [1:0] REG_GAMMA = 2'd2;

  logic [63:0] left_w_r, right_w_r;
  logic [15:0] gamma_r;
  logic        q_valid, q_ready, ok;
  item_t       q_item;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_w_r  <= 64'd4096;
      right_w_r <= 64'h1000_0000_0000_0000;
      gamma_r   <= 16'd5734;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LEFT:  left_w_r  <= cfg_data;
        REG_RIGHT: right_w_r <= cfg_data;
        REG_GAMMA: gamma_r   <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  ecpc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_data  (in_tdata),
    .in_last  (in_tlast),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_item   (q_item)
  );

  ecpc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .left_w    (left_w_r),
    .right_w   (right_w_r),
    .gamma     (gamma_r),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_item    (q_item),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_ok    (ok)
  );

  assign out_tdata = {7'd0, ok};

endmodule

/* hdl/ecpc_front.sv */
// Front end: accepts nodes, tags each with its row and column index,
// and buffers them in a two-entry queue. Depends on ecpc_pkg.
module ecpc_front import ecpc_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [127:0] in_data,
  input  logic         in_last,
  output logic         q_valid,
  input  logic         q_ready,
  output item_t        q_item
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NODES_PER_SIDE - 1);

  logic [IDX_W-1:0] ix_r, iy_r;
  item_t            buf_r [2];
  logic             wp_r, rp_r;
  logic [1:0]       cnt_r;
  logic             push, pop;
  item_t            tagged_item;

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign pop      = q_valid && q_ready;
  assign q_item   = buf_r[rp_r];

  // Classify the incoming node
  always_comb begin
    tagged_item.rho  = in_data[31:0];
    tagged_item.mx   = in_data[63:32];
    tagged_item.my   = in_data[95:64];
    tagged_item.e    = in_data[127:96];
    tagged_item.last = in_last;
    tagged_item.ix   = ix_r;
    tagged_item.iy   = iy_r;
  end

  // Advance position counters; restart on the last node
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ix_r <= '0;
      iy_r <= '0;
    end else if (push) begin
      if (in_last) begin
        ix_r <= '0;
        iy_r <= '0;
      end else if (ix_r == LAST_IDX) begin
        ix_r <= '0;
        iy_r <= (iy_r == LAST_IDX) ? '0 : iy_r + 1'b1;
      end else begin
        ix_r <= ix_r + 1'b1;
      end
    end
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) buf_r[wp_r] <= tagged_item;
  end

  // Queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

/* hdl/ecpc_back.sv */
// Back end: accumulates face extrapolations with one shared multiplier
// and runs the positivity tests. Depends on ecpc_pkg and the assert header.
module ecpc_back import ecpc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [63:0] left_w,
  input  logic [63:0] right_w,
  input  logic [15:0] gamma,
  input  logic        q_valid,
  output logic        q_ready,
  input  item_t       q_item,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_ok
);

`include "euler_cell_positivity_check_assert.svh"

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MUL  = 4'd1;
  localparam logic [3:0] S_ADD  = 4'd2;
  localparam logic [3:0] S_TLD  = 4'd3;
  localparam logic [3:0] S_TM0  = 4'd4;
  localparam logic [3:0] S_TM1  = 4'd5;
  localparam logic [3:0] S_TM2  = 4'd6;
  localparam logic [3:0] S_TEV  = 4'd7;
  localparam logic [3:0] S_DONE = 4'd8;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NODES_PER_SIDE - 1);

  logic [3:0]               state_r, state_nxt;
  item_t                    item_r;
  logic [3:0]               k_r;
  logic [2:0]               t_r;
  logic signed [63:0]       prod_r, a_r;
  logic [63:0]              b_r;
  logic signed [31:0]       t_rho_r, t_mx_r, t_my_r, t_e_r;
  logic                     valid_r;
  logic                     out_valid_r, out_ok_r;
  logic signed [ACC_W-1:0]  rl_r [NQ];
  logic signed [ACC_W-1:0]  rr_r [NQ];
  logic signed [ACC_W-1:0]  cb_r [16];
  logic signed [ACC_W-1:0]  ct_r [16];

  logic [1:0]               kind, q;
  logic signed [31:0]       u_q, w_q;
  logic signed [ACC_W-1:0]  sum_rd, sum_wr;
  logic signed [31:0]       mul_a, mul_b;
  logic signed [63:0]       mul_p;
  logic                     row_end, col_end, test_skip, test_ok, emit_ok;
  logic signed [ACC_W-1:0]  tsum [NQ];
  logic [63:0]              two_a;

  // Saturating accumulate at 48 bits
  function automatic logic signed [ACC_W-1:0] sat_add(logic signed [ACC_W-1:0] x,
                                                      logic signed [ACC_W-1:0] y);
    logic signed [ACC_W:0] s;
    s = {x[ACC_W-1], x} + {y[ACC_W-1], y};
    if (s[ACC_W] != s[ACC_W-1])
      sat_add = s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    else
      sat_add = s[ACC_W-1:0];
  endfunction

  // Round Q20.28 down to Q16.16 with saturation
  function automatic logic signed [31:0] to_q16(logic signed [ACC_W-1:0] v);
    logic signed [ACC_W:0] r;
    logic signed [ACC_W:0] sh;
    r  = {v[ACC_W-1], v} + (ACC_W+1)'(2048);
    sh = r >>> 12;
    if (sh > (ACC_W+1)'(64'sd2147483647))
      to_q16 = 32'sh7fffffff;
    else if (sh < -(ACC_W+1)'(64'sd2147483648))
      to_q16 = 32'sh80000000;
    else
      to_q16 = sh[31:0];
  endfunction

  assign kind    = k_r[3:2];
  assign q       = k_r[1:0];
  assign row_end = (item_r.ix == LAST_IDX);
  assign col_end = (item_r.iy == LAST_IDX);

  // Select operand and weight for one multiply-accumulate
  always_comb begin
    logic [IDX_W-1:0] widx;
    logic [63:0]      wreg;
    widx = kind[1] ? item_r.iy : item_r.ix;
    wreg = kind[0] ? right_w : left_w;
    w_q  = 32'(signed'(wreg[16*widx +: 16]));
    case (q)
      2'd0:    u_q = item_r.rho;
      2'd1:    u_q = item_r.mx;
      2'd2:    u_q = item_r.my;
      default: u_q = item_r.e;
    endcase
    case (kind)
      2'd0:    sum_rd = rl_r[q];
      2'd1:    sum_rd = rr_r[q];
      2'd2:    sum_rd = cb_r[{item_r.ix, q}];
      default: sum_rd = ct_r[{item_r.ix, q}];
    endcase
    sum_wr = sat_add(sum_rd, prod_r[ACC_W-1:0]);
  end

  // Shared multiplier
  always_comb begin
    case (state_r)
      S_TM0: begin
        mul_a = t_e_r;
        mul_b = t_rho_r;
      end
      S_TM1: begin
        mul_a = t_mx_r;
        mul_b = t_mx_r;
      end
      S_TM2: begin
        mul_a = t_my_r;
        mul_b = t_my_r;
      end
      default: begin
        mul_a = u_q;
        mul_b = w_q;
      end
    endcase
    mul_p = mul_a * mul_b;
  end

  // Pick the sums for the current face test
  always_comb begin
    for (int i = 0; i < NQ; i++) begin
      case (t_r)
        3'd1:    tsum[i] = rl_r[i];
        3'd2:    tsum[i] = rr_r[i];
        3'd3:    tsum[i] = cb_r[{item_r.ix, 2'(i)}];
        default: tsum[i] = ct_r[{item_r.ix, 2'(i)}];
      endcase
    end
    case (t_r)
      3'd1, 3'd2: test_skip = !row_end;
      3'd3, 3'd4: test_skip = !col_end;
      default:    test_skip = 1'b0;
    endcase
  end

  // Division-free pressure test
  always_comb begin
    two_a = (a_r > 0) ? {a_r[62:0], 1'b0} : 64'd0;
    if (t_rho_r <= 0)
      test_ok = 1'b0;
    else if (gamma > GAMMA_ONE)
      test_ok = (a_r > 0) && (two_a > b_r);
    else if (gamma < GAMMA_ONE)
      test_ok = (a_r <= 0) ? !(a_r == 0 && b_r == 64'd0) : (two_a < b_r);
    else
      test_ok = 1'b0;
  end

  assign q_ready = (state_r == S_IDLE);
  assign emit_ok = !out_valid_r || out_ready;

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (q_valid) state_nxt = S_MUL;
      S_MUL:  state_nxt = S_ADD;
      S_ADD:  state_nxt = (k_r == 4'd15) ? S_TLD : S_MUL;
      S_TLD: begin
        if (test_skip) state_nxt = (t_r == 3'd4) ? S_DONE : S_TLD;
        else           state_nxt = S_TM0;
      end
      S_TM0:  state_nxt = S_TM1;
      S_TM1:  state_nxt = S_TM2;
      S_TM2:  state_nxt = S_TEV;
      S_TEV:  state_nxt = (t_r == 3'd4) ? S_DONE : S_TLD;
      S_DONE: if (!item_r.last || emit_ok) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: if (q_valid) item_r <= q_item;
      S_MUL:  prod_r <= mul_p;
      S_TLD: begin
        if (t_r == 3'd0) begin
          t_rho_r <= item_r.rho;
          t_mx_r  <= item_r.mx;
          t_my_r  <= item_r.my;
          t_e_r   <= item_r.e;
        end else begin
          t_rho_r <= to_q16(tsum[0]);
          t_mx_r  <= to_q16(tsum[1]);
          t_my_r  <= to_q16(tsum[2]);
          t_e_r   <= to_q16(tsum[3]);
        end
      end
      S_TM0:  a_r <= mul_p;
      S_TM1:  b_r <= 64'(mul_p);
      S_TM2:  b_r <= b_r + 64'(mul_p);
      default: ;
    endcase
  end

  // Control, accumulators and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r         <= '0;
      t_r         <= '0;
      valid_r     <= 1'b1;
      out_valid_r <= 1'b0;
      out_ok_r    <= 1'b0;
      for (int i = 0; i < NQ; i++) begin
        rl_r[i] <= '0;
        rr_r[i] <= '0;
      end
      for (int i = 0; i < 16; i++) begin
        cb_r[i] <= '0;
        ct_r[i] <= '0;
      end
    end else begin
      // drop the taken result unless a new one replaces it this cycle
      if (out_valid_r && out_ready && !(state_r == S_DONE && item_r.last))
        out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          k_r <= '0;
          t_r <= '0;
        end
        S_ADD: begin
          k_r <= k_r + 1'b1;
          case (kind)
            2'd0:    rl_r[q] <= sum_wr;
            2'd1:    rr_r[q] <= sum_wr;
            2'd2:    cb_r[{item_r.ix, q}] <= sum_wr;
            default: ct_r[{item_r.ix, q}] <= sum_wr;
          endcase
        end
        S_TLD: if (test_skip) t_r <= t_r + 1'b1;
        S_TEV: begin
          t_r <= t_r + 1'b1;
          if (!test_ok) valid_r <= 1'b0;
        end
        S_DONE: begin
          if (!item_r.last || emit_ok) begin
            // drop finished row and column sums
            if (row_end || item_r.last) begin
              for (int i = 0; i < NQ; i++) begin
                rl_r[i] <= '0;
                rr_r[i] <= '0;
              end
            end
            for (int i = 0; i < 16; i++) begin
              if (item_r.last || (col_end && (4'(i) >> 2) == 4'(item_r.ix))) begin
                cb_r[i] <= '0;
                ct_r[i] <= '0;
              end
            end
            if (item_r.last) begin
              out_valid_r <= 1'b1;
              out_ok_r    <= valid_r;
              valid_r     <= 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_ok    = out_ok_r;

  `ECPC_ASSERT(a_emit_from_done, $rose(out_valid_r) |-> $past(state_r) == S_DONE, "result not from done")
  `ECPC_ASSERT(a_add_after_mul, state_r == S_ADD |-> $past(state_r) == S_MUL, "add without product")
  `ECPC_ASSERT(a_valid_rearmed, $rose(out_valid_r) |-> valid_r, "cell flag not rearmed")
  `ECPC_NEVER(a_take_while_busy, q_ready && state_r != S_IDLE, "queue popped while busy")

endmodule

/* verif/testbench.sv */
// Self-checking testbench for the Euler cell positivity checker.
// Streams cells of nodes, predicts cell_ok in a local model, compares results.
// Depends on ecpc_pkg and euler_cell_positivity_check.
`timescale 1ns / 100ps

module testbench;
  import ecpc_pkg::*;

  localparam logic [1:0] REG_LEFT  = 2'd0;
  localparam logic [1:0] REG_RIGHT = 2'd1;
  localparam logic [1:0] REG_GAMMA = 2'd2;
  localparam logic [1:0] REG_SPARE = 2'd3;
  localparam int  NODES      = NODES_PER_SIDE * NODES_PER_SIDE;
  localparam int  SETTLE     = 250;
  localparam int  CYCLE_CAP  = 600000;
  localparam longint SUM_MAX = 64'sd140737488355327;
  localparam longint SUM_MIN = -64'sd140737488355328;

  typedef struct {
    logic [31:0] rho;
    logic [31:0] mx;
    logic [31:0] my;
    logic [31:0] e;
    logic        last;
  } node_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [127:0] in_tdata = '0;   // density, momentum_x, momentum_y, total_energy
  logic         in_tlast = 1'b0; // last_node
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [7:0]   out_tdata;       // cell_ok, then zero fill
  logic         cfg_we = 1'b0;
  logic [1:0]   cfg_index = '0;
  logic [63:0]  cfg_data = '0;

  euler_cell_positivity_check dut (.*);

  always #10 clk = ~clk;

  // Local copy of configuration and cell state
  logic [63:0] left_w, right_w;
  logic [15:0] gamma_q;
  int          pos;
  longint      row_l[4], row_r[4], col_b[16], col_t[16];
  bit          cell_good;

  node_t pending_nodes[$];
  bit    expected_ok[$];
  int    errors = 0;
  int    accepted = 0;
  int    cycles = 0;
  bit    no_idle = 0;
  bit    in_took = 0;
  int    in_gap = 0;
  int    rdy_gap = 0;
  int    long_hold = 0;
  bit    long_done = 0;

  function automatic longint weight_at(logic [63:0] r, int k);
    return longint'($signed(r[16*k +: 16]));
  endfunction

  function automatic longint sat_add(longint a, longint p);
    longint s;
    s = a + p;
    if (s > SUM_MAX) return SUM_MAX;
    if (s < SUM_MIN) return SUM_MIN;
    return s;
  endfunction

  // Round Q20.28 to Q16.16 and clamp to 32 bits
  function automatic longint round_q16(longint v);
    longint q;
    q = (v + 2048) >>> 12;
    if (q > 64'sd2147483647) q = 64'sd2147483647;
    if (q < -64'sd2147483648) q = -64'sd2147483648;
    return q;
  endfunction

  // Density and division-free pressure test
  function automatic bit state_valid(longint rho, longint mx, longint my, longint e);
    longint      a;
    logic [63:0] b, two_a;
    if (rho <= 0) return 0;
    a = e * rho;
    b = 64'(mx * mx) + 64'(my * my);
    two_a = (a > 0) ? (64'(a) << 1) : 64'd0;
    if (gamma_q > GAMMA_ONE) return a > 0 && two_a > b;
    if (gamma_q < GAMMA_ONE) begin
      if (a <= 0) return !(a == 0 && b == 0);
      return two_a < b;
    end
    return 0;
  endfunction

  function automatic bit sums_valid(longint s0, longint s1, longint s2, longint s3);
    return state_valid(round_q16(s0), round_q16(s1), round_q16(s2), round_q16(s3));
  endfunction

  function automatic void clear_cell();
    pos = 0;
    cell_good = 1;
    for (int i = 0; i < 4; i++) begin
      row_l[i] = 0;
      row_r[i] = 0;
    end
    for (int i = 0; i < 16; i++) begin
      col_b[i] = 0;
      col_t[i] = 0;
    end
  endfunction

  // Advance the cell model by one node; returns 1 when a result is due
  function automatic bit predict_node(node_t n, output bit ok);
    longint u[4];
    int     ix, iy, base;
    u[0] = longint'($signed(n.rho));
    u[1] = longint'($signed(n.mx));
    u[2] = longint'($signed(n.my));
    u[3] = longint'($signed(n.e));
    ix = pos % NODES_PER_SIDE;
    iy = pos / NODES_PER_SIDE;
    base = ix * 4;
    if (!state_valid(u[0], u[1], u[2], u[3])) cell_good = 0;
    for (int q = 0; q < 4; q++) begin
      row_l[q] = sat_add(row_l[q], u[q] * weight_at(left_w, ix));
      row_r[q] = sat_add(row_r[q], u[q] * weight_at(right_w, ix));
      col_b[base+q] = sat_add(col_b[base+q], u[q] * weight_at(left_w, iy));
      col_t[base+q] = sat_add(col_t[base+q], u[q] * weight_at(right_w, iy));
    end
    if (ix == NODES_PER_SIDE - 1) begin
      if (!sums_valid(row_l[0], row_l[1], row_l[2], row_l[3]) ||
          !sums_valid(row_r[0], row_r[1], row_r[2], row_r[3])) cell_good = 0;
      for (int q = 0; q < 4; q++) begin
        row_l[q] = 0;
        row_r[q] = 0;
      end
    end
    if (iy == NODES_PER_SIDE - 1) begin
      if (!sums_valid(col_b[base], col_b[base+1], col_b[base+2], col_b[base+3]) ||
          !sums_valid(col_t[base], col_t[base+1], col_t[base+2], col_t[base+3]))
        cell_good = 0;
      for (int q = 0; q < 4; q++) begin
        col_b[base+q] = 0;
        col_t[base+q] = 0;
      end
    end
    pos = (pos + 1 >= NODES) ? 0 : pos + 1;
    ok = cell_good;
    if (n.last) begin
      clear_cell();
      return 1;
    end
    return 0;
  endfunction

  // Node generators: physical state or raw bits
  function automatic node_t phys_node(bit last);
    node_t n;
    n.rho = 32'($urandom_range(1 << 12, 1 << 22));
    n.mx = 32'($signed($urandom_range(0, 1 << 16)) - (1 << 15));
    n.my = 32'($signed($urandom_range(0, 1 << 16)) - (1 << 15));
    n.e = 32'($urandom_range(1 << 16, 1 << 24));
    n.last = last;
    return n;
  endfunction

  function automatic node_t raw_node(bit last);
    node_t n;
    n.rho = $urandom;
    n.mx = $urandom;
    n.my = $urandom;
    n.e = $urandom;
    n.last = last;
    return n;
  endfunction

  function automatic node_t mk_node(logic [31:0] r, logic [31:0] x, logic [31:0] y,
                                    logic [31:0] en, bit last);
    node_t n;
    n.rho = r;
    n.mx = x;
    n.my = y;
    n.e = en;
    n.last = last;
    return n;
  endfunction

  // Queue one cell of count nodes; noisy sets the chance, in sixteenths, that a node is raw
  task automatic add_cell(int count, bit mark_last, int noisy);
    for (int i = 0; i < count; i++) begin
      bit lst;
      lst = mark_last && (i == count - 1);
      if (noisy > 0 && $urandom_range(0, 15) < noisy) pending_nodes.push_back(raw_node(lst));
      else pending_nodes.push_back(phys_node(lst));
    end
  endtask

  task automatic write_reg(logic [1:0] idx, logic [63:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_LEFT:  left_w = val;
      REG_RIGHT: right_w = val;
      REG_GAMMA: gamma_q = val[15:0];
      default: ;
    endcase
  endtask

  // Hold until all items are in and all results out, then let the engine drain
  task automatic wait_idle();
    while (pending_nodes.size() != 0 || in_tvalid || expected_ok.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic random_cells(int count);
    int target;
    target = accepted + pending_nodes.size() + count;
    while (accepted + pending_nodes.size() < target) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: add_cell(NODES, 1, ($urandom_range(0, 3) == 0) ? 1 : 0);
        6: add_cell($urandom_range(1, NODES - 1), 1, $urandom_range(0, 2));
        7: add_cell(NODES + $urandom_range(1, NODES), 1, 0);
        8: add_cell($urandom_range(1, 4), 1, 16);
        default: add_cell(NODES, 1, 4);
      endcase
    end
  endtask

  // Drive items at the falling edge, idling in bursts
  always @(negedge clk) begin
    if (rst_n && (!in_tvalid || in_took)) begin
      if (in_gap > 0) begin
        in_tvalid <= 1'b0;
        in_gap--;
      end else if (pending_nodes.size() != 0) begin
        node_t n;
        n = pending_nodes.pop_front();
        in_tdata <= {n.e, n.my, n.mx, n.rho};
        in_tlast <= n.last;
        in_tvalid <= 1'b1;
        if (!no_idle && $urandom_range(0, 7) == 0) in_gap = $urandom_range(1, 8);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver readiness: bursts of back-pressure plus one long hold
  always @(negedge clk) begin
    if (!long_done && accepted >= 400) begin
      long_done = 1;
      long_hold = 3000;
    end
    if (long_hold > 0) begin
      out_tready <= 1'b0;
      long_hold--;
    end else if (no_idle) begin
      out_tready <= 1'b1;
    end else if (rdy_gap > 0) begin
      out_tready <= 1'b0;
      rdy_gap--;
    end else begin
      out_tready <= 1'b1;
      if ($urandom_range(0, 9) == 0) rdy_gap = $urandom_range(1, 8);
    end
  end

  // Sample handshakes, predict and compare at the rising edge
  always @(posedge clk) begin
    bit ok, due;
    node_t n;
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("FAIL");
      $finish;
    end else begin
      in_took <= in_tvalid && in_tready;
      if (rst_n && in_tvalid && in_tready) begin
        n = mk_node(in_tdata[31:0], in_tdata[63:32], in_tdata[95:64], in_tdata[127:96],
                    in_tlast);
        due = predict_node(n, ok);
        if (due) expected_ok.push_back(ok);
        accepted++;
      end
      if (rst_n && out_tvalid && out_tready) begin
        if (expected_ok.size() == 0) begin
          $error("cell_ok: unexpected result, actual %0b", out_tdata[0]);
          errors++;
        end else begin
          ok = expected_ok.pop_front();
          if (out_tdata[0] !== ok) begin
            $error("cell_ok: expected %0b, actual %0b", ok, out_tdata[0]);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    left_w = 64'd4096;
    right_w = 64'h1000_0000_0000_0000;
    gamma_q = 16'd5734;
    clear_cell();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: field extremes, early last, defaults
    pending_nodes.push_back(mk_node(32'h7FFF_FFFF, 32'h0, 32'h0, 32'h7FFF_FFFF, 1));
    pending_nodes.push_back(mk_node(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                                    32'h8000_0000, 1));
    pending_nodes.push_back(mk_node(32'h0, 32'h0, 32'h0, 32'h0001_0000, 1));
    pending_nodes.push_back(mk_node(32'h0001_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                                    32'h7FFF_FFFF, 1));
    pending_nodes.push_back(mk_node(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                    32'hFFFF_FFFF, 1));
    add_cell(NODES, 1, 0);
    add_cell(3, 1, 0);
    wait_idle();

    // Gamma equal to one fails every pressure test; below one flips the sign
    write_reg(REG_GAMMA, 64'(GAMMA_ONE));
    add_cell(2, 1, 0);
    pending_nodes.push_back(mk_node(32'h0001_0000, 32'h0, 32'h0, 32'h0, 1));
    wait_idle();
    write_reg(REG_GAMMA, 64'd0);
    pending_nodes.push_back(mk_node(32'h0001_0000, 32'h0, 32'h0, 32'h0, 1));
    pending_nodes.push_back(mk_node(32'h0001_0000, 32'h0001_0000, 32'h0, 32'h0, 1));
    pending_nodes.push_back(mk_node(32'h0001_0000, 32'h0, 32'h0, 32'h8000_0000, 1));
    add_cell(NODES, 1, 0);
    wait_idle();

    // Random phases across settings; unused register index is ignored
    write_reg(REG_GAMMA, 64'd65535);
    write_reg(REG_SPARE, {$urandom, $urandom});
    random_cells(180);
    wait_idle();

    write_reg(REG_LEFT, 64'h0800_0800_0800_0800);
    write_reg(REG_RIGHT, 64'h0400_0400_0400_0400);
    write_reg(REG_GAMMA, 64'd5734);
    random_cells(180);
    wait_idle();

    write_reg(REG_LEFT, {$urandom, $urandom});
    write_reg(REG_RIGHT, {$urandom, $urandom});
    write_reg(REG_GAMMA, 64'($urandom_range(0, 65535)));
    random_cells(150);
    wait_idle();

    write_reg(REG_LEFT, 64'h7FFF_7FFF_7FFF_7FFF);
    write_reg(REG_RIGHT, 64'h8000_8000_8000_8000);
    write_reg(REG_GAMMA, 64'd4097);
    random_cells(120);
    wait_idle();

    write_reg(REG_LEFT, 64'h0);
    write_reg(REG_RIGHT, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(REG_GAMMA, 64'd4095);
    random_cells(100);
    wait_idle();

    write_reg(REG_LEFT, 64'd4096);
    write_reg(REG_RIGHT, 64'h1000_0000_0000_0000);
    write_reg(REG_GAMMA, 64'd5734);
    random_cells(200);
    wait_idle();

    // Closing stretch at full rate
    no_idle = 1;
    random_cells(150);
    wait_idle();

    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
